// File: hw/rtl/fxalu_pkg.sv
// Shared types, opcodes and widths for the fixed-point ALU.
`timescale 1ns / 1ps
package fxalu_pkg;
  localparam int VALUE_WIDTH = 32;
  localparam int FRACTION_BITS = 8;
  localparam int KIND_WIDTH = 4;
  localparam int STATUS_WIDTH = 2;
  // Dividend width for division: |a| shifted up by the fraction bits plus a round bit.
  localparam int DIV_NUM_WIDTH = VALUE_WIDTH + FRACTION_BITS + 1;
  localparam int DIV_DEN_WIDTH = VALUE_WIDTH + 1;
  localparam int DIV_STEPS_PER_STAGE = 8;
  localparam int DIV_STAGES = (DIV_NUM_WIDTH + DIV_STEPS_PER_STAGE - 1) / DIV_STEPS_PER_STAGE;
  localparam int DIV_BITS = DIV_STAGES * DIV_STEPS_PER_STAGE;
  localparam int WIDE_WIDTH = 2 * VALUE_WIDTH + 2;

  localparam logic [KIND_WIDTH-1:0] KIND_ADD = 4'd0;
  localparam logic [KIND_WIDTH-1:0] KIND_SUB = 4'd1;
  localparam logic [KIND_WIDTH-1:0] KIND_MUL = 4'd2;
  localparam logic [KIND_WIDTH-1:0] KIND_DIV = 4'd3;
  localparam logic [KIND_WIDTH-1:0] KIND_GT = 4'd4;
  localparam logic [KIND_WIDTH-1:0] KIND_LT = 4'd5;
  localparam logic [KIND_WIDTH-1:0] KIND_GE = 4'd6;
  localparam logic [KIND_WIDTH-1:0] KIND_LE = 4'd7;
  localparam logic [KIND_WIDTH-1:0] KIND_EQ = 4'd8;
  localparam logic [KIND_WIDTH-1:0] KIND_NE = 4'd9;
  localparam logic [KIND_WIDTH-1:0] KIND_MIN = 4'd10;
  localparam logic [KIND_WIDTH-1:0] KIND_MAX = 4'd11;
  localparam logic [KIND_WIDTH-1:0] KIND_INC = 4'd12;
  localparam logic [KIND_WIDTH-1:0] KIND_DEC = 4'd13;
  localparam logic [KIND_WIDTH-1:0] KIND_TOINT = 4'd14;
  localparam logic [KIND_WIDTH-1:0] KIND_FROMINT = 4'd15;

  localparam logic [STATUS_WIDTH-1:0] STATUS_OK = 2'd0;
  localparam logic [STATUS_WIDTH-1:0] STATUS_OVERFLOW = 2'd1;
  localparam logic [STATUS_WIDTH-1:0] STATUS_DIV_ZERO = 2'd2;

  // One division lane as it walks through the restoring stages.
  typedef struct packed {
    logic [DIV_BITS-1:0] num;
    logic [DIV_NUM_WIDTH:0] rem;
    logic [DIV_BITS-1:0] quo;
    logic [DIV_DEN_WIDTH-1:0] den;
  } div_lane_t;

  // An item after the front stage: a wide signed result still to be finished.
  typedef struct packed {
    logic [KIND_WIDTH-1:0] kind;
    logic signed [WIDE_WIDTH-1:0] wide;
    logic neg;
    logic cmp;
    logic div_zero;
    logic mul_round;
  } item_t;

  // Clamp a wide signed value to the value range.
  function automatic logic [VALUE_WIDTH+STATUS_WIDTH-1:0] saturate(
      input logic signed [WIDE_WIDTH-1:0] x);
    logic signed [WIDE_WIDTH-1:0] hi;
    logic signed [WIDE_WIDTH-1:0] lo;
    hi = (WIDE_WIDTH'(1) <<< (VALUE_WIDTH - 1)) - WIDE_WIDTH'(1);
    lo = -hi - WIDE_WIDTH'(1);
    if (x > hi) return {hi[VALUE_WIDTH-1:0], STATUS_OVERFLOW};
    if (x < lo) return {lo[VALUE_WIDTH-1:0], STATUS_OVERFLOW};
    return {x[VALUE_WIDTH-1:0], STATUS_OK};
  endfunction
endpackage

// File: hw/rtl/fxalu_div_stage.sv
// One block of restoring-division steps with its output register.
`timescale 1ns / 1ps
module fxalu_div_stage (
  input  logic clk,
  input  logic advance,
  input  fxalu_pkg::div_lane_t lane_in,
  output fxalu_pkg::div_lane_t lane_out
);
  fxalu_pkg::div_lane_t lane_next;

  // Shift in one numerator bit per step and subtract the divisor where it fits.
  always_comb begin
    logic [fxalu_pkg::DIV_NUM_WIDTH:0] r;
    logic [fxalu_pkg::DIV_BITS-1:0] n;
    logic [fxalu_pkg::DIV_BITS-1:0] q;
    r = lane_in.rem;
    n = lane_in.num;
    q = lane_in.quo;
    for (int i = 0; i < fxalu_pkg::DIV_STEPS_PER_STAGE; i++) begin
      r = {r[fxalu_pkg::DIV_NUM_WIDTH-1:0], n[fxalu_pkg::DIV_BITS-1]};
      n = {n[fxalu_pkg::DIV_BITS-2:0], 1'b0};
      if (r >= (fxalu_pkg::DIV_NUM_WIDTH+1)'(lane_in.den)) begin
        r = r - (fxalu_pkg::DIV_NUM_WIDTH+1)'(lane_in.den);
        q = {q[fxalu_pkg::DIV_BITS-2:0], 1'b1};
      end else begin
        q = {q[fxalu_pkg::DIV_BITS-2:0], 1'b0};
      end
    end
    lane_next.rem = r;
    lane_next.num = n;
    lane_next.quo = q;
    lane_next.den = lane_in.den;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      lane_out <= lane_next;
    end
  end
endmodule

// File: hw/rtl/fxalu_front.sv
// Front stage: decodes the opcode, forms the per-opcode wide value or compare outcome, and sets up the division lane.
`timescale 1ns / 1ps
module fxalu_front (
  input  logic clk,
  input  logic advance,
  input  logic [fxalu_pkg::KIND_WIDTH-1:0] kind,
  input  logic signed [fxalu_pkg::VALUE_WIDTH-1:0] operand_a,
  input  logic signed [fxalu_pkg::VALUE_WIDTH-1:0] operand_b,
  output fxalu_pkg::item_t item,
  output fxalu_pkg::div_lane_t lane
);
  localparam int W = fxalu_pkg::WIDE_WIDTH;
  fxalu_pkg::item_t item_next;
  fxalu_pkg::div_lane_t lane_next;
  logic signed [W-1:0] a;
  logic signed [W-1:0] b;
  logic [fxalu_pkg::VALUE_WIDTH:0] mag_a;
  logic [fxalu_pkg::VALUE_WIDTH:0] mag_b;
  logic [2*fxalu_pkg::VALUE_WIDTH-1:0] mag_prod;

  assign a = W'(operand_a);
  assign b = W'(operand_b);
  assign mag_a = operand_a[fxalu_pkg::VALUE_WIDTH-1] ? (fxalu_pkg::VALUE_WIDTH+1)'(-a)
                                                     : (fxalu_pkg::VALUE_WIDTH+1)'(a);
  assign mag_b = operand_b[fxalu_pkg::VALUE_WIDTH-1] ? (fxalu_pkg::VALUE_WIDTH+1)'(-b)
                                                     : (fxalu_pkg::VALUE_WIDTH+1)'(b);

  // Magnitudes never exceed 2^31, so their low bits carry the whole value
  // and one unsigned 32 by 32 product gives the full 64-bit result.
  assign mag_prod = {{fxalu_pkg::VALUE_WIDTH{1'b0}}, mag_a[fxalu_pkg::VALUE_WIDTH-1:0]}
                  * {{fxalu_pkg::VALUE_WIDTH{1'b0}}, mag_b[fxalu_pkg::VALUE_WIDTH-1:0]};

  // Per-opcode wide value; multiply keeps the full product for later rounding.
  always_comb begin
    item_next.kind = kind;
    item_next.neg = operand_a[fxalu_pkg::VALUE_WIDTH-1] ^ operand_b[fxalu_pkg::VALUE_WIDTH-1];
    item_next.cmp = 1'b0;
    item_next.div_zero = (operand_b == '0);
    item_next.mul_round = 1'b0;
    item_next.wide = '0;
    unique case (kind)
      fxalu_pkg::KIND_ADD: item_next.wide = a + b;
      fxalu_pkg::KIND_SUB: item_next.wide = a - b;
      fxalu_pkg::KIND_MUL: begin
        item_next.wide = W'(mag_prod);
        item_next.mul_round = 1'b1;
      end
      fxalu_pkg::KIND_DIV: item_next.wide = '0;
      fxalu_pkg::KIND_GT: item_next.cmp = a > b;
      fxalu_pkg::KIND_LT: item_next.cmp = a < b;
      fxalu_pkg::KIND_GE: item_next.cmp = a >= b;
      fxalu_pkg::KIND_LE: item_next.cmp = a <= b;
      fxalu_pkg::KIND_EQ: item_next.cmp = a == b;
      fxalu_pkg::KIND_NE: item_next.cmp = a != b;
      fxalu_pkg::KIND_MIN: item_next.wide = (a < b) ? a : b;
      fxalu_pkg::KIND_MAX: item_next.wide = (a > b) ? a : b;
      fxalu_pkg::KIND_INC: item_next.wide = a + W'(1);
      fxalu_pkg::KIND_DEC: item_next.wide = a - W'(1);
      fxalu_pkg::KIND_TOINT: item_next.wide = a >>> fxalu_pkg::FRACTION_BITS;
      fxalu_pkg::KIND_FROMINT: item_next.wide = a <<< fxalu_pkg::FRACTION_BITS;
      default: item_next.wide = '0;
    endcase
  end

  // Division dividend is 2*|a|*2^F + |b|, divisor 2*|b|, which yields rounded quotient.
  always_comb begin
    logic [fxalu_pkg::DIV_BITS-1:0] d;
    d = (fxalu_pkg::DIV_BITS'(mag_a) << (fxalu_pkg::FRACTION_BITS + 1))
        + fxalu_pkg::DIV_BITS'(mag_b);
    lane_next.num = d;
    lane_next.rem = '0;
    lane_next.quo = '0;
    lane_next.den = fxalu_pkg::DIV_DEN_WIDTH'({mag_b, 1'b0});
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      item <= item_next;
      lane <= lane_next;
    end
  end
endmodule

// File: hw/rtl/fixed_point_alu.sv
// Top level of the pipelined signed fixed-point ALU.
//   channel | signals                               | role
//   in      | in_valid, in_ready, kind, operand_a/b | one operation per beat
//   out     | out_valid, out_ready, result_value,   | one result per beat
//           | compare_true, status                  |
// One beat per cycle enters and leaves while the output is not stalled; the path
// runs through the front stage, the restoring divider stages, and the finishing stage.
// The divider's eight quotient bits per stage set the depth.
// Reset clears the valid bits only. A stall holds every stage in place.
`timescale 1ns / 1ps
module fixed_point_alu (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic [fxalu_pkg::KIND_WIDTH-1:0] kind,
  input  logic signed [fxalu_pkg::VALUE_WIDTH-1:0] operand_a,
  input  logic signed [fxalu_pkg::VALUE_WIDTH-1:0] operand_b,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [fxalu_pkg::VALUE_WIDTH-1:0] result_value,
  output logic compare_true,
  output logic [fxalu_pkg::STATUS_WIDTH-1:0] status
);
  localparam int S = fxalu_pkg::DIV_STAGES;
  localparam int W = fxalu_pkg::WIDE_WIDTH;
  logic advance;
  logic [S+1:0] valid;
  fxalu_pkg::item_t items [S+1];
  fxalu_pkg::div_lane_t lanes [S+1];

  // Whole pipeline moves together unless the output beat is stuck.
  assign advance = !out_valid || out_ready;
  assign in_ready = advance;
  assign out_valid = valid[S+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (advance) begin
      valid <= {valid[S:0], in_valid};
    end
  end

  fxalu_front u_front (
    .clk(clk), .advance(advance), .kind(kind), .operand_a(operand_a),
    .operand_b(operand_b), .item(items[0]), .lane(lanes[0])
  );

  // Divider stages with the side data riding alongside.
  for (genvar g = 0; g < S; g++) begin : g_div
    fxalu_div_stage u_stage (
      .clk(clk), .advance(advance), .lane_in(lanes[g]), .lane_out(lanes[g+1])
    );
    always_ff @(posedge clk) begin
      if (advance) begin
        items[g+1] <= items[g];
      end
    end
  end

  // Finishing stage: rounding, sign, saturation and status.
  logic signed [fxalu_pkg::VALUE_WIDTH-1:0] result_next;
  logic cmp_next;
  logic [fxalu_pkg::STATUS_WIDTH-1:0] status_next;
  always_comb begin
    fxalu_pkg::item_t it;
    logic [W-1:0] mag;
    logic signed [W-1:0] v;
    it = items[S];
    cmp_next = it.cmp;
    mag = '0;
    v = it.wide;
    if (it.kind == fxalu_pkg::KIND_MUL) begin
      mag = (it.wide + (W'(1) << (fxalu_pkg::FRACTION_BITS - 1))) >> fxalu_pkg::FRACTION_BITS;
      v = it.neg ? -$signed(mag) : $signed(mag);
    end else if (it.kind == fxalu_pkg::KIND_DIV) begin
      mag = W'(lanes[S].quo);
      v = it.neg ? -$signed(mag) : $signed(mag);
    end
    {result_next, status_next} = fxalu_pkg::saturate(v);
    if (it.kind == fxalu_pkg::KIND_DIV && it.div_zero) begin
      result_next = '0;
      status_next = fxalu_pkg::STATUS_DIV_ZERO;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result_value <= result_next;
      compare_true <= cmp_next;
      status <= status_next;
    end
  end
endmodule

// File: hw/rtl/fxalu_checker.sv
// Port-level checks for the fixed-point ALU, bound to the top level.
`timescale 1ns / 1ps
module fxalu_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic signed [fxalu_pkg::VALUE_WIDTH-1:0] result_value,
  input logic compare_true,
  input logic [fxalu_pkg::STATUS_WIDTH-1:0] status
);
  // A waiting result stays put while stalled.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(result_value) && $stable(status))
    else $error("output beat changed while stalled");
  // Input is refused only while the output is stalled.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input refused without output stall");
  // Status never takes an unused code.
  a_status: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> status != 2'd3)
    else $error("bad status code");
  // A true comparison outcome carries a zero value and ok status.
  a_cmp: assert property (@(posedge clk) disable iff (rst)
    out_valid && compare_true |-> result_value == '0 && status == fxalu_pkg::STATUS_OK)
    else $error("compare beat carries a value");
endmodule

bind fixed_point_alu fxalu_checker u_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .result_value(result_value),
  .compare_true(compare_true), .status(status)
);
